@@ src/pbd_pkg.sv @@
`default_nettype none

package pbd_pkg;

  // Request codes.
  localparam logic [2:0] REQ_GET      = 3'd0;
  localparam logic [2:0] REQ_NEW_NODE = 3'd1;
  localparam logic [2:0] REQ_NEW_ROOT = 3'd2;
  localparam logic [2:0] REQ_GET_ROOT = 3'd3;
  localparam logic [2:0] REQ_RETURN   = 3'd4;
  localparam logic [2:0] REQ_DIRTY    = 3'd5;

  // Response status codes.
  localparam logic [1:0] STS_DONE     = 2'd0;
  localparam logic [1:0] STS_FILL     = 2'd1;
  localparam logic [1:0] STS_NO_FRAME = 2'd2;
  localparam logic [1:0] STS_ABSENT   = 2'd3;

  // Frame states.
  localparam logic [1:0] FS_FREE     = 2'd0;
  localparam logic [1:0] FS_PINNED   = 2'd1;
  localparam logic [1:0] FS_RELEASED = 2'd2;
  localparam logic [1:0] FS_DIRTY    = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] node_id;
  } pbd_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame;
    logic [15:0] result_node;
    logic        write_back;
  } pbd_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } pbd_cmd_t;

endpackage

`default_nettype wire

@@ src/pbd_ctrl.sv @@
`default_nettype none

module pbd_ctrl
  import pbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pbd_cmd_t cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  assign req_ready   = (state == IDLE);
  assign cmd.capture = req_valid && (state == IDLE);
  // The update is applied only when the response register can take its result.
  assign cmd.exec    = (state == EXEC) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            state <= EXEC;
          end
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        EXEC: begin
          if (!rsp_valid || rsp_ready) begin
            state     <= IDLE;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == EXEC))
    else $error("accepted request did not move to execution");

  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (rsp_valid && state == IDLE))
    else $error("executed request produced no response");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == EXEC && rsp_valid && !rsp_ready) |=> (state == EXEC))
    else $error("execution left while the response was stalled");
`endif

endmodule

`default_nettype wire

@@ src/pbd_datapath.sv @@
`default_nettype none

module pbd_datapath
  import pbd_pkg::*;
#(
  parameter int FRAMES  = 16,
  parameter int ID_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  pbd_cmd_t cmd,
  input  pbd_req_t req,
  output pbd_rsp_t rsp
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [ID_BITS:0] COUNT_MAX = {1'b1, {ID_BITS{1'b0}}};

  logic [1:0]         frame_state [FRAMES];
  logic [ID_BITS-1:0] frame_tag   [FRAMES];
  logic [ID_BITS:0]   node_count;
  logic [ID_BITS-1:0] root_node;
  logic               root_present;

  // Request and search results captured at acceptance.
  logic [2:0]         req_q;
  logic [ID_BITS-1:0] id_q;
  logic               hit_q;
  logic               hit_dirty_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic               take_q;
  logic [IDX_W-1:0]   take_idx_q;

  logic [ID_BITS-1:0] id_sel;
  logic               hit;
  logic               hit_dirty;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               rel_found;
  logic [IDX_W-1:0]   rel_idx;

  always_comb begin
    if (req.req_type == REQ_GET_ROOT && root_present) begin
      id_sel = root_node;
    end else begin
      id_sel = ID_BITS'(req.node_id);
    end
  end

  // Lowest-index searches: scanning downwards lets the lowest match win.
  always_comb begin
    hit        = 1'b0;
    hit_dirty  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    rel_found  = 1'b0;
    rel_idx    = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (frame_state[i] != FS_FREE && frame_tag[i] == id_sel) begin
        hit       = 1'b1;
        hit_dirty = (frame_state[i] == FS_DIRTY);
        hit_idx   = IDX_W'(i);
      end
      if (frame_state[i] == FS_FREE) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (frame_state[i] == FS_RELEASED) begin
        rel_found = 1'b1;
        rel_idx   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q       <= req.req_type;
      id_q        <= id_sel;
      hit_q       <= hit;
      hit_dirty_q <= hit_dirty;
      hit_idx_q   <= hit_idx;
      take_q      <= free_found || rel_found;
      take_idx_q  <= free_found ? free_idx : rel_idx;
    end
  end

  // Execution decisions.
  logic               is_new;
  logic               is_get;
  logic               st_en;
  logic [IDX_W-1:0]   st_idx;
  logic [1:0]         st_val;
  logic               tag_en;
  logic [ID_BITS-1:0] tag_val;
  logic               count_inc;
  logic               root_set;
  logic [ID_BITS-1:0] new_id;
  pbd_rsp_t           rsp_next;

  assign new_id = node_count[ID_BITS-1:0];

  always_comb begin
    is_new = (req_q == REQ_NEW_NODE) || (req_q == REQ_NEW_ROOT)
          || (req_q == REQ_GET_ROOT && !root_present);
    is_get = (req_q == REQ_GET) || (req_q == REQ_GET_ROOT && root_present);

    st_en     = 1'b0;
    st_idx    = hit_idx_q;
    st_val    = FS_PINNED;
    tag_en    = 1'b0;
    tag_val   = id_q;
    count_inc = 1'b0;
    root_set  = 1'b0;
    rsp_next  = '0;

    if (is_new) begin
      if (take_q) begin
        st_en     = 1'b1;
        st_idx    = take_idx_q;
        tag_en    = 1'b1;
        tag_val   = new_id;
        count_inc = (node_count != COUNT_MAX);
        root_set  = (req_q != REQ_NEW_NODE);
        rsp_next.status      = STS_DONE;
        rsp_next.frame       = 4'(take_idx_q);
        rsp_next.result_node = 16'(new_id);
        rsp_next.write_back  = 1'b1;
      end else begin
        rsp_next.status = STS_NO_FRAME;
      end
    end else if (is_get) begin
      rsp_next.result_node = 16'(id_q);
      if (hit_q) begin
        st_en          = !hit_dirty_q;
        rsp_next.frame = 4'(hit_idx_q);
      end else if (take_q) begin
        st_en           = 1'b1;
        st_idx          = take_idx_q;
        tag_en          = 1'b1;
        rsp_next.status = STS_FILL;
        rsp_next.frame  = 4'(take_idx_q);
      end else begin
        rsp_next.status = STS_NO_FRAME;
      end
    end else if (req_q == REQ_RETURN || req_q == REQ_DIRTY) begin
      rsp_next.result_node = 16'(id_q);
      if (!hit_q) begin
        rsp_next.status = STS_ABSENT;
      end else begin
        rsp_next.frame = 4'(hit_idx_q);
        if (req_q == REQ_DIRTY) begin
          st_en  = 1'b1;
          st_val = FS_DIRTY;
        end else if (!(root_present && id_q == root_node)) begin
          // The root stays pinned; other frames are released and flushed if dirty.
          st_en               = 1'b1;
          st_val              = FS_RELEASED;
          rsp_next.write_back = hit_dirty_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_state[i] <= FS_FREE;
      end
      node_count   <= '0;
      root_node    <= '0;
      root_present <= 1'b0;
    end else if (cmd.exec) begin
      if (st_en) begin
        frame_state[st_idx] <= st_val;
      end
      if (count_inc) begin
        node_count <= node_count + 1'b1;
      end
      if (root_set) begin
        root_node    <= new_id;
        root_present <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (tag_en) begin
        frame_tag[take_idx_q] <= tag_val;
      end
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= COUNT_MAX)
    else $error("node counter passed its saturation value");

  a_root_set: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && root_set) |=> (root_present && root_node == $past(new_id)))
    else $error("new root was not recorded");

  a_no_frame_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && rsp_next.status == STS_NO_FRAME) |=> $stable(node_count))
    else $error("an id was consumed although no frame was available");
`endif

endmodule

`default_nettype wire

@@ src/page_buffer_directory.sv @@
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  pbd_req_t: req_type, node_id
// rsp      out        rsp_valid / rsp_ready  pbd_rsp_t: status, frame, result_node, write_back
//
// The tag match and the free and released frame searches run on the request as it is accepted;
// the frame state update and response register write follow in the EXEC state, once the
// response register can take the result. One response per request.
// Synchronous active-high reset marks every frame free and clears the counter and root.
// A stalled response holds the update back; a new request is taken while a
// finished response waits, as long as the previous one has been applied.

module page_buffer_directory
  import pbd_pkg::*;
#(
  parameter int FRAMES  = 16,
  parameter int ID_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pbd_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pbd_rsp_t rsp
);

  pbd_cmd_t cmd;

  pbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  pbd_datapath #(
    .FRAMES  (FRAMES),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire
